>>> src/kmwm_pkg.sv
// ----------------------------------------------------------------------------
// kmwm_pkg: shared types and constants of the k-mismatch window matcher
// Request codes, register indexes, channel payloads and the control bundle
// that the top level broadcasts to the row of compare cells.
// ----------------------------------------------------------------------------
package kmwm_pkg;

  // default configuration of the cell row and of the position counter
  localparam int unsigned PATTERN_MAX_DEF   = 64;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // configuration register port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] LEN_RESET    = 7'd64;
  localparam logic [CFG_DATA_W-1:0] BUDGET_RESET = 7'd6;

  // largest reported mismatch count
  localparam logic [6:0] COUNT_MAX = 7'd127;

  // request codes of an input item
  typedef enum logic [1:0] {
    REQ_PATTERN  = 2'd0,
    REQ_TEXT     = 2'd1,
    REQ_NEW_TEXT = 2'd2
  } req_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH  = 2'd0,
    CFG_MISMATCH_BUDGET = 2'd1
  } cfg_e;

  // input item
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_value;
  } in_t;

  // result item
  typedef struct packed {
    logic        match;
    logic [31:0] window_start;
    logic [6:0]  mismatch_count;
  } out_t;

  // control broadcast to every cell
  typedef struct packed {
    logic       step;       // shift text and counts by one byte
    logic [7:0] step_byte;  // byte compared in every cell on a step
    logic       pat_we;     // write pattern byte at the fill index
    logic [7:0] pat_byte;
    logic       res_adv;    // move the result row by one slot
    logic       inject;     // drop a finished count into the result row
  } ctl_t;

endpackage

>>> src/kmwm_cell.sv
// ----------------------------------------------------------------------------
// kmwm_cell: one compare cell of the matcher row
// Holds one pattern byte, one text byte, the running mismatch count of the
// window that currently reaches this pattern offset, and one result slot.
// ----------------------------------------------------------------------------
module kmwm_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned FILL_W = 7,
  parameter int unsigned IDX_W  = 6,
  parameter int unsigned CNT_W  = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kmwm_pkg::ctl_t       ctl_i,
  input  logic [FILL_W-1:0]    pat_fill_i,
  input  logic [IDX_W-1:0]     lm1_i,
  input  logic [31:0]          start_i,
  input  logic [7:0]           txt_i,
  output logic [7:0]           txt_o,
  input  logic [CNT_W-1:0]     cnt_i,
  output logic [CNT_W-1:0]     cnt_o,
  input  logic                 res_vld_i,
  input  logic [CNT_W-1:0]     res_cnt_i,
  input  logic [31:0]          res_start_i,
  output logic                 res_vld_o,
  output logic [CNT_W-1:0]     res_cnt_o,
  output logic [31:0]          res_start_o
);

  logic [7:0]       pat_q;
  logic [7:0]       txt_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             res_vld_q, res_vld_d;
  logic [CNT_W-1:0] res_cnt_q, res_cnt_d;
  logic [31:0]      res_start_q, res_start_d;
  logic             here;

  // add this offset's mismatch to the count handed over by the neighbor
  assign cnt_d = cnt_i + CNT_W'(ctl_i.step_byte != pat_q);

  // this cell closes the window when it sits at the last pattern offset
  assign here = (lm1_i == IDX_W'(IDX));

  // take a fresh result here, otherwise take the neighbor's slot
  always_comb begin
    if (ctl_i.inject && here) begin
      res_vld_d   = 1'b1;
      res_cnt_d   = cnt_d;
      res_start_d = start_i;
    end else begin
      res_vld_d   = res_vld_i;
      res_cnt_d   = res_cnt_i;
      res_start_d = res_start_i;
    end
  end

  // pattern byte, text byte, count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= '0;
      txt_q     <= '0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (ctl_i.pat_we && (pat_fill_i == FILL_W'(IDX))) begin
        pat_q <= ctl_i.pat_byte;
      end
      if (ctl_i.step) begin
        txt_q <= txt_i;
        cnt_q <= cnt_d;
      end
      if (ctl_i.res_adv) begin
        res_vld_q <= res_vld_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_adv) begin
      res_cnt_q   <= res_cnt_d;
      res_start_q <= res_start_d;
    end
  end

  assign txt_o       = txt_q;
  assign cnt_o       = cnt_q;
  assign res_vld_o   = res_vld_q;
  assign res_cnt_o   = res_cnt_q;
  assign res_start_o = res_start_q;

endmodule

>>> src/k_mismatch_window_matcher.sv
// ----------------------------------------------------------------------------
// k_mismatch_window_matcher: byte fragment search with a mismatch budget
// A row of PATTERN_MAX compare cells counts mismatches of every text window
// against the loaded pattern; finished counts travel down a result row.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   kmwm_pkg::in_t
//   out      output     out_valid_o / out_stall_i kmwm_pkg::out_t
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A text byte, a new-text request or a pattern load before any text is taken
// at one item per cycle while the output is not stalled. A pattern load while
// text is held replays the stored window through the count row and stalls the
// input until the replay ends. Results pass down the result row to the output.
// Reset clears the pattern to zero, length 64, budget 6, no text held.
// A stalled output freezes the result row and stalls the input.
// ----------------------------------------------------------------------------
module k_mismatch_window_matcher #(
  parameter int unsigned PATTERN_MAX   = kmwm_pkg::PATTERN_MAX_DEF,
  parameter int unsigned POSITION_BITS = kmwm_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  kmwm_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output kmwm_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kmwm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kmwm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned CNT_W  = FILL_W;
  localparam int unsigned CMP_W  = (FILL_W > kmwm_pkg::CFG_DATA_W) ?
                                   FILL_W : kmwm_pkg::CFG_DATA_W;
  localparam int unsigned SUB_W  = (POSITION_BITS > IDX_W) ? POSITION_BITS : IDX_W;

  // configuration registers
  logic [kmwm_pkg::CFG_DATA_W-1:0] len_q, bud_q;

  // control state
  logic [FILL_W-1:0]        pat_fill_q, pat_fill_d;
  logic [FILL_W-1:0]        win_fill_q, win_fill_d, fill_new;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     replay_q, replay_d;
  logic [IDX_W-1:0]         rep_cnt_q, rep_cnt_d;
  logic                     out_valid_q;
  kmwm_pkg::out_t           out_q;

  // handshake and decode
  logic in_acc, is_pat, is_text, is_new, pat_write, advance;
  logic [IDX_W-1:0]         lm1;
  logic [CMP_W-1:0]         len_x;
  logic [SUB_W-1:0]         start_diff;
  logic [POSITION_BITS-1:0] start_full;
  logic [31:0]              start32;
  kmwm_pkg::ctl_t           ctl;

  // cell row links
  logic [7:0]       txt   [PATTERN_MAX];
  logic [CNT_W-1:0] cnt   [PATTERN_MAX];
  logic             rvld  [PATTERN_MAX];
  logic [CNT_W-1:0] rcnt  [PATTERN_MAX];
  logic [31:0]      rstart[PATTERN_MAX];

  logic [CMP_W-1:0] last_cnt;

  // result row moves whenever the output register is free or taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = replay_q || !advance;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_pat     = in_acc && (in_data_i.req_type == kmwm_pkg::REQ_PATTERN);
  assign is_text    = in_acc && (in_data_i.req_type == kmwm_pkg::REQ_TEXT);
  assign is_new     = in_acc && (in_data_i.req_type == kmwm_pkg::REQ_NEW_TEXT);
  assign pat_write  = is_pat && (pat_fill_q != FILL_W'(PATTERN_MAX));

  assign cfg_ready_o = 1'b1;

  // effective window length minus one
  assign len_x = CMP_W'(len_q);
  always_comb begin
    priority if (len_q == '0) begin
      lm1 = '0;
    end else if (len_x > CMP_W'(PATTERN_MAX)) begin
      lm1 = IDX_W'(PATTERN_MAX - 1);
    end else begin
      lm1 = IDX_W'(len_x - CMP_W'(1));
    end
  end

  // window fill saturates at the row length
  assign fill_new = (win_fill_q == FILL_W'(PATTERN_MAX)) ? win_fill_q :
                    win_fill_q + FILL_W'(1);

  // window start of the byte taken now
  assign start_diff = SUB_W'(pos_q) - SUB_W'(lm1);
  assign start_full = start_diff[POSITION_BITS-1:0];
  generate
    if (POSITION_BITS >= 32) begin : g_start_cut
      assign start32 = start_full[31:0];
    end else begin : g_start_ext
      assign start32 = {{(32 - POSITION_BITS){1'b0}}, start_full};
    end
  endgenerate

  // broadcast control: a replay step feeds back the oldest stored byte
  always_comb begin
    ctl.step      = is_text || replay_q;
    ctl.step_byte = replay_q ? txt[PATTERN_MAX-1] : in_data_i.byte_value;
    ctl.pat_we    = pat_write;
    ctl.pat_byte  = in_data_i.byte_value;
    ctl.res_adv   = advance;
    ctl.inject    = is_text && (CMP_W'(fill_new) > CMP_W'(lm1));
  end

  // next control state
  always_comb begin
    pat_fill_d = pat_fill_q;
    win_fill_d = win_fill_q;
    pos_d      = pos_q;
    replay_d   = replay_q;
    rep_cnt_d  = rep_cnt_q;
    if (pat_write) begin
      pat_fill_d = pat_fill_q + FILL_W'(1);
      if (win_fill_q != '0) begin
        replay_d  = 1'b1;
        rep_cnt_d = '0;
      end
    end
    if (is_text) begin
      win_fill_d = fill_new;
      pos_d      = pos_q + POSITION_BITS'(1);
    end
    if (is_new) begin
      win_fill_d = '0;
      pos_d      = '0;
    end
    if (replay_q) begin
      rep_cnt_d = rep_cnt_q + IDX_W'(1);
      if (rep_cnt_q == IDX_W'(PATTERN_MAX - 1)) begin
        replay_d = 1'b0;
      end
    end
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= kmwm_pkg::LEN_RESET;
      bud_q       <= kmwm_pkg::BUDGET_RESET;
      pat_fill_q  <= '0;
      win_fill_q  <= '0;
      pos_q       <= '0;
      replay_q    <= 1'b0;
      rep_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == kmwm_pkg::CFG_PATTERN_LENGTH) begin
          len_q <= cfg_data_i;
        end
        if (cfg_index_i == kmwm_pkg::CFG_MISMATCH_BUDGET) begin
          bud_q <= cfg_data_i;
        end
      end
      pat_fill_q <= pat_fill_d;
      win_fill_q <= win_fill_d;
      pos_q      <= pos_d;
      replay_q   <= replay_d;
      rep_cnt_q  <= rep_cnt_d;
      if (advance) begin
        out_valid_q <= rvld[PATTERN_MAX-1];
      end
    end
  end

  // output register: flag and saturate the count leaving the row
  assign last_cnt = CMP_W'(rcnt[PATTERN_MAX-1]);
  always_ff @(posedge clk_i) begin
    if (advance && rvld[PATTERN_MAX-1]) begin
      out_q.match          <= last_cnt < CMP_W'(bud_q);
      out_q.window_start   <= rstart[PATTERN_MAX-1];
      out_q.mismatch_count <= (last_cnt > CMP_W'(kmwm_pkg::COUNT_MAX)) ?
                              kmwm_pkg::COUNT_MAX : last_cnt[6:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // row of compare cells
  generate
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      logic [7:0]       txt_in;
      logic [CNT_W-1:0] cnt_in;
      logic             rvld_in;
      logic [CNT_W-1:0] rcnt_in;
      logic [31:0]      rstart_in;

      if (j == 0) begin : g_head
        assign txt_in    = ctl.step_byte;
        assign cnt_in    = '0;
        assign rvld_in   = 1'b0;
        assign rcnt_in   = '0;
        assign rstart_in = '0;
      end else begin : g_link
        assign txt_in    = txt[j-1];
        assign cnt_in    = cnt[j-1];
        assign rvld_in   = rvld[j-1];
        assign rcnt_in   = rcnt[j-1];
        assign rstart_in = rstart[j-1];
      end

      kmwm_cell #(
        .IDX    (j),
        .FILL_W (FILL_W),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl),
        .pat_fill_i  (pat_fill_q),
        .lm1_i       (lm1),
        .start_i     (start32),
        .txt_i       (txt_in),
        .txt_o       (txt[j]),
        .cnt_i       (cnt_in),
        .cnt_o       (cnt[j]),
        .res_vld_i   (rvld_in),
        .res_cnt_i   (rcnt_in),
        .res_start_i (rstart_in),
        .res_vld_o   (rvld[j]),
        .res_cnt_o   (rcnt[j]),
        .res_start_o (rstart[j])
      );
    end
  endgenerate

endmodule
